>>> rtl/assert_macros.svh
// Assertion macros used by the port-level checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> rtl/rtt_pkg.sv
// Package for the request tag tracker: field widths, codes and beat structs.
// No dependencies.
`default_nettype none

package rtt_pkg;

  localparam int TAG_COUNT_DEF = 16;

  localparam int REQ_W     = 2;
  localparam int TAG_IN_W  = 4;
  localparam int STATUS_W  = 3;
  localparam int TAG_OUT_W = 4;
  localparam int MASK_W    = 16;
  localparam int CNT_W     = 8;

  localparam logic [CNT_W-1:0] TIMEOUT_RESET = 8'd5;

  typedef enum logic [REQ_W-1:0] {
    REQ_NEW   = 2'd0,
    REQ_REPLY = 2'd1,
    REQ_TICK  = 2'd2
  } req_type_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ASSIGNED = 3'd0,
    ST_FULL     = 3'd1,
    ST_MATCH    = 3'd2,
    ST_UNKNOWN  = 3'd3,
    ST_TICK     = 3'd4
  } status_t;

  typedef struct packed {
    req_type_t             kind;
    logic [TAG_IN_W-1:0]   tag;
  } op_t;

  typedef struct packed {
    status_t               status;
    logic [TAG_OUT_W-1:0]  tag;
    logic [MASK_W-1:0]     mask;
  } result_t;

endpackage

`default_nettype wire

>>> rtl/rtt_prio_enc.sv
// Lowest-set-bit priority encoder used to pick the lowest free tag.
// Depends on nothing outside this file.
`default_nettype none

module rtt_prio_enc #(
  parameter int N = 16
) (
  input  wire logic [N-1:0]         req,
  output logic                      found,
  output logic [$clog2(N)-1:0]      index
);

  localparam int IDX_W = $clog2(N);

  always_comb begin
    found = |req;
    index = '0;
    for (int i = N - 1; i >= 0; i--) begin
      if (req[i]) begin
        index = IDX_W'(i);
      end
    end
  end

endmodule

`default_nettype wire

>>> rtl/rtt_table.sv
// Tag table: valid bits, countdowns and the single-pass update per beat.
// Depends on rtt_pkg and rtt_prio_enc.
`default_nettype none

module rtt_table #(
  parameter int TAG_COUNT = rtt_pkg::TAG_COUNT_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          op_valid,
  input  wire rtt_pkg::op_t                  op,
  input  wire logic [rtt_pkg::CNT_W-1:0]     timeout,
  output rtt_pkg::result_t                   res
);

  localparam int IDX_W = $clog2(TAG_COUNT);

  logic [TAG_COUNT-1:0]       valid;
  logic [TAG_COUNT-1:0]       valid_next;
  logic [rtt_pkg::CNT_W-1:0]  cnt      [TAG_COUNT];
  logic [rtt_pkg::CNT_W-1:0]  cnt_next [TAG_COUNT];
  logic [TAG_COUNT-1:0]       expired;
  logic                       free_found;
  logic [IDX_W-1:0]           free_idx;
  logic                       reply_in_range;
  logic [IDX_W-1:0]           reply_idx;

  rtt_prio_enc #(
    .N (TAG_COUNT)
  ) u_prio_enc (
    .req   (~valid),
    .found (free_found),
    .index (free_idx)
  );

  assign reply_in_range = int'(op.tag) < TAG_COUNT;
  assign reply_idx      = IDX_W'(op.tag);

  always_comb begin
    valid_next = valid;
    cnt_next   = cnt;
    expired    = '0;
    res.status = rtt_pkg::ST_TICK;
    res.tag    = '0;
    res.mask   = '0;
    case (op.kind)
      rtt_pkg::REQ_NEW: begin
        if (free_found) begin
          valid_next[free_idx] = 1'b1;
          cnt_next[free_idx]   = timeout;
          res.status           = rtt_pkg::ST_ASSIGNED;
          res.tag              = rtt_pkg::TAG_OUT_W'(free_idx);
        end else begin
          res.status = rtt_pkg::ST_FULL;
        end
      end
      rtt_pkg::REQ_REPLY: begin
        if (reply_in_range && valid[reply_idx]) begin
          valid_next[reply_idx] = 1'b0;
          cnt_next[reply_idx]   = '0;
          res.status            = rtt_pkg::ST_MATCH;
        end else begin
          res.status = rtt_pkg::ST_UNKNOWN;
        end
      end
      rtt_pkg::REQ_TICK: begin
        for (int i = 0; i < TAG_COUNT; i++) begin
          if (valid[i]) begin
            if (cnt[i] <= rtt_pkg::CNT_W'(1)) begin
              valid_next[i] = 1'b0;
              cnt_next[i]   = '0;
              expired[i]    = 1'b1;
            end else begin
              cnt_next[i] = cnt[i] - rtt_pkg::CNT_W'(1);
            end
          end
        end
        res.mask = rtt_pkg::MASK_W'(expired);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (op_valid) begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (op_valid) begin
      cnt <= cnt_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/request_tag_tracker_with_timeout_core.sv
// Timing: a beat is registered in op/op_valid; done and res are then registered together.
// Throughput: one beat per cycle; busy is high only during reset.
// Reset: synchronous, clears all tags and loads the timeout register with 5.
// Results cannot be stalled; each stays on the ports until the next result is registered.
// Depends on rtt_pkg and rtt_table.
`default_nettype none

module request_tag_tracker_with_timeout_core #(
  parameter int TAG_COUNT = rtt_pkg::TAG_COUNT_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [rtt_pkg::REQ_W-1:0]         req_type,
  input  wire logic [rtt_pkg::TAG_IN_W-1:0]      reply_tag,
  output logic                                   done,
  output logic [rtt_pkg::STATUS_W-1:0]           status,
  output logic [rtt_pkg::TAG_OUT_W-1:0]          assigned_tag,
  output logic [rtt_pkg::MASK_W-1:0]             expired_mask,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [rtt_pkg::CNT_W-1:0]         cfg_data
);

  logic                       op_valid;
  rtt_pkg::op_t               op;
  logic [rtt_pkg::CNT_W-1:0]  timeout;
  rtt_pkg::result_t           res_next;
  rtt_pkg::result_t           res;
  logic                       take;

  assign busy      = rst;
  assign cfg_ready = 1'b1;
  assign take      = start && !busy;

  rtt_table #(
    .TAG_COUNT (TAG_COUNT)
  ) u_table (
    .clk      (clk),
    .rst      (rst),
    .op_valid (op_valid),
    .op       (op),
    .timeout  (timeout),
    .res      (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      op_valid <= 1'b0;
      done     <= 1'b0;
      timeout  <= rtt_pkg::TIMEOUT_RESET;
    end else begin
      op_valid <= take;
      done     <= op_valid;
      if (cfg_valid && cfg_ready) begin
        timeout <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      op.kind <= rtt_pkg::req_type_t'(req_type);
      op.tag  <= reply_tag;
    end
    if (op_valid) begin
      res <= res_next;
    end
  end

  assign status       = res.status;
  assign assigned_tag = res.tag;
  assign expired_mask = res.mask;

endmodule

`default_nettype wire

>>> rtl/rtt_checker.sv
// Port-level checker for the tag tracker core, with its bind statement.
// Depends on rtt_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module rtt_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              start,
  input wire logic                              busy,
  input wire logic                              done,
  input wire logic [rtt_pkg::STATUS_W-1:0]      status,
  input wire logic [rtt_pkg::TAG_OUT_W-1:0]     assigned_tag,
  input wire logic [rtt_pkg::MASK_W-1:0]        expired_mask
);

  `ASSERT_NEXT(a_beat_gives_result, clk, rst, start && !busy, ##1 done)
  `ASSERT_IMPLIES(a_result_has_beat, clk, rst, done, $past(start && !busy, 2))
  `ASSERT_IMPLIES(a_mask_only_on_tick, clk, rst, done && status != rtt_pkg::ST_TICK, expired_mask == '0)
  `ASSERT_IMPLIES(a_tag_only_on_assign, clk, rst, done && status != rtt_pkg::ST_ASSIGNED, assigned_tag == '0)

endmodule

bind request_tag_tracker_with_timeout_core rtt_checker u_rtt_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .done         (done),
  .status       (status),
  .assigned_tag (assigned_tag),
  .expired_mask (expired_mask)
);

`default_nettype wire
